// File: sv/fgn_pkg.sv
// shared types, constants and helper functions of the fractal gradient noise unit
package fgn_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int MAX_OCTAVES_DEF = 12;

	localparam int PERM_ENTRIES   = 128;
	localparam int PERM_AW        = $clog2(PERM_ENTRIES);
	localparam int PERM_VAL_W     = 8;
	localparam int GRADIENT_COUNT = 16;
	localparam int GRAD_W         = $clog2(GRADIENT_COUNT);

	localparam int FRAC_W     = 16;
	localparam int RESULT_W   = 16;
	localparam int ONE_Q16    = 65536;
	localparam int OFFSET_Q16 = 46341;
	localparam int REMAP_Q16  = 46341;
	localparam int HALF_Q16   = 32768;
	localparam int FADE_C15   = 15 * ONE_Q16;
	localparam int FADE_C10   = 10 * ONE_Q16;

	// shared multiplier operand and product widths, plus working datapath widths
	localparam int MA_W   = 24;
	localparam int MB_W   = 18;
	localparam int PROD_W = MA_W + MB_W;
	localparam int WK_W   = MA_W;
	localparam int AMP_W  = 17;
	localparam int LG_W   = 5;
	localparam int SH_W   = 6;

	// accumulator split for the final scaling multiply
	localparam int ACC_SPLIT = 20;

	localparam int DIV_NUM_W_DEF = 34 + $clog2(MAX_OCTAVES_DEF) + 17;
	localparam int DIV_DEN_W_DEF = 16 + $clog2(MAX_OCTAVES_DEF) + FRAC_W;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 2'd2;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic signed [MB_W-1:0] GRAD_X [GRADIENT_COUNT] = '{
		18'sd0, 18'sd25080, 18'sd46341, 18'sd60547,
		18'sd65536, 18'sd60547, 18'sd46341, 18'sd25080,
		18'sd0, -18'sd25080, -18'sd46341, -18'sd60547,
		-18'sd65536, -18'sd60547, -18'sd46341, -18'sd25080
	};
	localparam logic signed [MB_W-1:0] GRAD_Y [GRADIENT_COUNT] = '{
		18'sd65536, 18'sd60547, 18'sd46341, 18'sd25080,
		18'sd0, -18'sd25080, -18'sd46341, -18'sd60547,
		-18'sd65536, -18'sd60547, -18'sd46341, -18'sd25080,
		18'sd0, 18'sd25080, 18'sd46341, 18'sd60547
	};

	typedef enum logic [5:0] {
		S_IDLE, S_OCT, S_AMP, S_RA0, S_RA1, S_RB00, S_RB10, S_RB01, S_RB11,
		S_D0X, S_D0Y, S_D1X, S_D1Y, S_D2X, S_D2Y, S_D3X, S_D3Y,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
		S_L0, S_L1, S_L2, S_L3, S_W0, S_W1,
		S_M0, S_M1, S_M2, S_DGO, S_DIV, S_DONE
	} fgn_state_t;

	// divide by 2^16, round to nearest, ties away from zero
	function automatic logic signed [WK_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (mag + PROD_W'(HALF_Q16)) >> FRAC_W;
		return v[PROD_W-1] ? WK_W'(-r) : WK_W'(r);
	endfunction

	// clamp a fade value to 0..1.0
	function automatic logic signed [WK_W-1:0] clamp_one(input logic signed [WK_W-1:0] t);
		logic signed [WK_W-1:0] r;
		r = t;
		if (t < 0)
			r = '0;
		else if (t > WK_W'(ONE_Q16))
			r = WK_W'(ONE_Q16);
		return r;
	endfunction

endpackage

// File: sv/fractal_gradient_noise_2d_unit.sv
// fractal gradient noise unit: permutation table, octave sequencer and shared multiplier
// a pixel transfer runs every octave through the sequencer, then the final scaling and divide;
// a table load writes one permutation entry while idle and gives no result
// throughput: one pixel at a time, busy stays high until done; the single shared multiplier
// and the bit-serial divider set the rate
// reset: arst_n clears the sequencer, config goes to 8/4/32768; done is a one-cycle strobe
module fractal_gradient_noise_2d_unit import fgn_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [PERM_AW-1:0]    table_index,
	input  logic [PERM_VAL_W-1:0] table_value,
	// result side
	output logic                  done,
	output logic [RESULT_W-1:0]   noise_value
);

	localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
	localparam int ACC_W  = 34 + $clog2(MAX_OCTAVES);
	localparam int WSUM_W = 16 + $clog2(MAX_OCTAVES);
	localparam int NUM_W  = ACC_W + 17;
	localparam int DEN_W  = WSUM_W + FRAC_W;
	localparam int EXT_W  = PERM_AW + COORD_BITS;
	localparam int WIDE_W = EXT_W + FRAC_W;

	fgn_state_t state_q, state_d;

	// configuration registers
	logic [3:0]  size_log2_q;
	logic [3:0]  octave_count_q;
	logic [15:0] persistence_q;

	// per-pixel working registers
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [OCT_W-1:0]      o_q;
	logic [AMP_W-1:0]      amp_q;
	logic [WSUM_W-1:0]     wsum_q;
	logic [ACC_W-1:0]      acc_q;
	logic [NUM_W-1:0]      num_q;
	logic [PERM_AW-1:0]    cx_q, cy_q;
	logic [FRAC_W-1:0]     fx_q, fy_q;
	logic [PERM_VAL_W-1:0] a0_q, a1_q;
	logic [GRAD_W-1:0]     g00_q, g10_q, g01_q, g11_q;
	logic signed [PROD_W-1:0] sum_q;
	logic signed [WK_W-1:0]   d00_q, d10_q, d01_q, d11_q;
	logic signed [WK_W-1:0]   tu_q, tv_q, l0_q, l1_q, r_q;
	logic [RESULT_W-1:0]      res_q;

	// permutation table and its registered read port
	logic [PERM_VAL_W-1:0] perm_mem [PERM_ENTRIES];
	logic [PERM_VAL_W-1:0] rd_q;
	logic [PERM_AW-1:0]    rd_addr;

	// shared multiplier
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_q;

	// divider
	logic                div_start;
	logic                div_done;
	logic [RESULT_W-1:0] div_q;

	// decoded config and handshake
	logic                  idle;
	logic                  load_we;
	logic                  pixel_go;
	logic [LG_W-1:0]       lg_c;
	logic [LG_W-1:0]       oc5_c;
	logic [OCT_W-1:0]      oc_c;
	logic [15:0]           p_c;
	logic [COORD_BITS-1:0] edge_mask;
	logic                  last_oct;

	// cell and fraction of the current octave
	logic [SH_W-1:0]       o6, lg6, sh_c;
	logic [WIDE_W-1:0]     wide_x, wide_y;
	logic [EXT_W-1:0]      shl_x, shl_y;
	logic [PERM_AW-1:0]    cx_c, cy_c;
	logic [FRAC_W-1:0]     fx_c, fy_c;

	// datapath helpers
	logic signed [MA_W-1:0]   dx0, dx1, dy0, dy1, t0x, t0y;
	logic signed [MB_W-1:0]   fxb, fyb;
	logic [PROD_W-1:0]        amp_rnd;
	logic [AMP_W-1:0]         amp_new;
	logic signed [WK_W-1:0]   prod_r;
	logic signed [WK_W-1:0]   dot_r;
	logic signed [WK_W-1:0]   term_c;

	assign idle     = state_q == S_IDLE;
	assign load_we  = start && idle && command == CMD_LOAD;
	assign pixel_go = start && idle && command == CMD_PIXEL;
	assign busy     = !idle;
	assign done     = state_q == S_DONE;
	assign noise_value = res_q;

	// clamp the config to its legal range
	always_comb begin
		lg_c = LG_W'(size_log2_q);
		if (lg_c < LG_W'(3))
			lg_c = LG_W'(3);
		else if (lg_c > LG_W'(COORD_BITS))
			lg_c = LG_W'(COORD_BITS);
		oc5_c = LG_W'(octave_count_q);
		if (oc5_c == '0)
			oc5_c = LG_W'(1);
		else if (oc5_c > LG_W'(MAX_OCTAVES))
			oc5_c = LG_W'(MAX_OCTAVES);
		oc_c = OCT_W'(oc5_c);
		p_c  = (persistence_q == '0) ? 16'd1 : persistence_q;
		for (int i = 0; i < COORD_BITS; i++)
			edge_mask[i] = LG_W'(i) < lg_c;
	end

	assign last_oct = ({1'b0, o_q} + (OCT_W + 1)'(1)) == {1'b0, oc_c};

	// cell index and fraction: coarse octaves shift right, finer than a pixel shifts left
	always_comb begin
		o6     = SH_W'(o_q);
		lg6    = SH_W'(lg_c);
		sh_c   = '0;
		wide_x = '0;
		wide_y = '0;
		shl_x  = '0;
		shl_y  = '0;
		if (o6 <= lg6) begin
			sh_c   = lg6 - o6;
			wide_x = {{PERM_AW{1'b0}}, px_q, {FRAC_W{1'b0}}} >> sh_c;
			wide_y = {{PERM_AW{1'b0}}, py_q, {FRAC_W{1'b0}}} >> sh_c;
			cx_c   = wide_x[FRAC_W +: PERM_AW];
			cy_c   = wide_y[FRAC_W +: PERM_AW];
			fx_c   = wide_x[FRAC_W-1:0];
			fy_c   = wide_y[FRAC_W-1:0];
		end else begin
			sh_c  = o6 - lg6;
			shl_x = {{PERM_AW{1'b0}}, px_q} << sh_c;
			shl_y = {{PERM_AW{1'b0}}, py_q} << sh_c;
			cx_c  = shl_x[PERM_AW-1:0];
			cy_c  = shl_y[PERM_AW-1:0];
			fx_c  = '0;
			fy_c  = '0;
		end
	end

	// corner offsets, fade seeds and rounded products
	assign dx0 = MA_W'({1'b0, fx_q});
	assign dy0 = MA_W'({1'b0, fy_q});
	assign dx1 = dx0 - MA_W'(ONE_Q16);
	assign dy1 = dy0 - MA_W'(ONE_Q16);
	assign t0x = (dx0 <<< 2) + (dx0 <<< 1) - MA_W'(FADE_C15);
	assign t0y = (dy0 <<< 2) + (dy0 <<< 1) - MA_W'(FADE_C15);
	assign fxb = MB_W'({1'b0, fx_q});
	assign fyb = MB_W'({1'b0, fy_q});
	assign amp_rnd = PROD_W'(prod_q) + PROD_W'(HALF_Q16);
	assign amp_new = AMP_W'(amp_rnd >> FRAC_W);
	assign prod_r  = rnd16(prod_q);
	assign dot_r   = rnd16(sum_q + prod_q);
	assign term_c  = l0_q + prod_r + WK_W'(OFFSET_Q16);

	// multiplier operands and table address per step
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		rd_addr = '0;
		case (state_q)
			S_OCT:  begin mul_a = MA_W'(amp_q); mul_b = MB_W'(p_c); end
			S_AMP:  rd_addr = cy_q;
			S_RA0:  rd_addr = cy_q + PERM_AW'(1);
			S_RA1:  rd_addr = PERM_AW'(a0_q) + cx_q;
			S_RB00: rd_addr = PERM_AW'(a0_q) + cx_q + PERM_AW'(1);
			S_RB10: rd_addr = PERM_AW'(a1_q) + cx_q;
			S_RB01: rd_addr = PERM_AW'(a1_q) + cx_q + PERM_AW'(1);
			S_D0X:  begin mul_a = dx0; mul_b = GRAD_X[g00_q]; end
			S_D0Y:  begin mul_a = dy0; mul_b = GRAD_Y[g00_q]; end
			S_D1X:  begin mul_a = dx1; mul_b = GRAD_X[g10_q]; end
			S_D1Y:  begin mul_a = dy0; mul_b = GRAD_Y[g10_q]; end
			S_D2X:  begin mul_a = dx0; mul_b = GRAD_X[g01_q]; end
			S_D2Y:  begin mul_a = dy1; mul_b = GRAD_Y[g01_q]; end
			S_D3X:  begin mul_a = dx1; mul_b = GRAD_X[g11_q]; end
			S_D3Y:  begin mul_a = dy1; mul_b = GRAD_Y[g11_q]; end
			// the two fades interleave so each product is registered before that fade's next step
			S_F0:   begin mul_a = t0x;  mul_b = fxb; end
			S_F1:   begin mul_a = t0y;  mul_b = fyb; end
			S_F2, S_F4, S_F6: begin mul_a = tu_q; mul_b = fxb; end
			S_F3, S_F5, S_F7: begin mul_a = tv_q; mul_b = fyb; end
			S_F8:   begin mul_a = d10_q - d00_q; mul_b = MB_W'(tu_q); end
			S_L0:   begin mul_a = d11_q - d01_q; mul_b = MB_W'(tu_q); end
			S_L2:   begin mul_a = l1_q - l0_q;   mul_b = MB_W'(tv_q); end
			S_W0:   begin mul_a = r_q; mul_b = MB_W'(amp_q); end
			S_M0:   begin mul_a = MA_W'(acc_q[ACC_SPLIT-1:0]); mul_b = MB_W'(REMAP_Q16); end
			S_M1:   begin mul_a = MA_W'(acc_q[ACC_W-1:ACC_SPLIT]); mul_b = MB_W'(REMAP_Q16); end
			default: ;
		endcase
	end

	fgn_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign div_start = state_q == S_DGO && wsum_q != '0;

	fgn_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_q),
		.den      ({wsum_q, {FRAC_W{1'b0}}}),
		.done     (div_done),
		.quotient (div_q)
	);

	// permutation table
	always_ff @(posedge clk) begin
		if (load_we)
			perm_mem[table_index] <= table_value;
		rd_q <= perm_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q    <= 4'd8;
			octave_count_q <= 4'd4;
			persistence_q  <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE_LOG2:    size_log2_q    <= cfg_data[3:0];
				CFG_OCTAVE_COUNT: octave_count_q <= cfg_data[3:0];
				CFG_PERSISTENCE:  persistence_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (pixel_go) state_d = S_OCT;
			S_OCT:  state_d = S_AMP;
			S_AMP:  state_d = S_RA0;
			S_RA0:  state_d = S_RA1;
			S_RA1:  state_d = S_RB00;
			S_RB00: state_d = S_RB10;
			S_RB10: state_d = S_RB01;
			S_RB01: state_d = S_RB11;
			S_RB11: state_d = S_D0X;
			S_D0X:  state_d = S_D0Y;
			S_D0Y:  state_d = S_D1X;
			S_D1X:  state_d = S_D1Y;
			S_D1Y:  state_d = S_D2X;
			S_D2X:  state_d = S_D2Y;
			S_D2Y:  state_d = S_D3X;
			S_D3X:  state_d = S_D3Y;
			S_D3Y:  state_d = S_F0;
			S_F0:   state_d = S_F1;
			S_F1:   state_d = S_F2;
			S_F2:   state_d = S_F3;
			S_F3:   state_d = S_F4;
			S_F4:   state_d = S_F5;
			S_F5:   state_d = S_F6;
			S_F6:   state_d = S_F7;
			S_F7:   state_d = S_F8;
			S_F8:   state_d = S_L0;
			S_L0:   state_d = S_L1;
			S_L1:   state_d = S_L2;
			S_L2:   state_d = S_L3;
			S_L3:   state_d = S_W0;
			S_W0:   state_d = S_W1;
			S_W1:   state_d = last_oct ? S_M0 : S_OCT;
			S_M0:   state_d = S_M1;
			S_M1:   state_d = S_M2;
			S_M2:   state_d = S_DGO;
			S_DGO:  state_d = (wsum_q == '0) ? S_DONE : S_DIV;
			S_DIV:  if (div_done) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath: each multiply result is consumed in the step after the one that issued it
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pixel_go) begin
					px_q   <= pixel_x & edge_mask;
					py_q   <= pixel_y & edge_mask;
					o_q    <= '0;
					amp_q  <= AMP_W'(ONE_Q16);
					wsum_q <= '0;
					acc_q  <= '0;
				end
			end
			S_OCT: begin
				cx_q <= cx_c;
				cy_q <= cy_c;
				fx_q <= fx_c;
				fy_q <= fy_c;
			end
			S_AMP: begin
				amp_q  <= amp_new;
				wsum_q <= wsum_q + WSUM_W'(amp_new);
			end
			S_RA0:  a0_q  <= rd_q;
			S_RA1:  a1_q  <= rd_q;
			S_RB00: g00_q <= rd_q[GRAD_W-1:0];
			S_RB10: g10_q <= rd_q[GRAD_W-1:0];
			S_RB01: g01_q <= rd_q[GRAD_W-1:0];
			S_RB11: g11_q <= rd_q[GRAD_W-1:0];
			S_D0Y, S_D1Y, S_D2Y, S_D3Y: sum_q <= prod_q;
			S_D1X: d00_q <= dot_r;
			S_D2X: d10_q <= dot_r;
			S_D3X: d01_q <= dot_r;
			S_F0:  d11_q <= dot_r;
			S_F1:  tu_q <= prod_r + WK_W'(FADE_C10);
			S_F2:  tv_q <= prod_r + WK_W'(FADE_C10);
			S_F3, S_F5: tu_q <= prod_r;
			S_F4, S_F6: tv_q <= prod_r;
			S_F7:  tu_q <= clamp_one(prod_r);
			S_F8:  tv_q <= clamp_one(prod_r);
			S_L0:  l0_q <= d00_q + prod_r;
			S_L1:  l1_q <= d01_q + prod_r;
			S_L3:  r_q  <= (term_c < 0) ? '0 : term_c;
			S_W1: begin
				acc_q <= acc_q + ACC_W'(prod_q);
				o_q   <= o_q + OCT_W'(1);
			end
			S_M1:  num_q <= NUM_W'(prod_q);
			// add the high partial product and half the divisor for rounding
			S_M2:  num_q <= num_q + (NUM_W'(prod_q) << ACC_SPLIT)
				+ (NUM_W'(wsum_q) << (FRAC_W - 1));
			S_DGO: if (wsum_q == '0) res_q <= {RESULT_W{1'b1}};
			S_DIV: if (div_done) res_q <= div_q;
			default: ;
		endcase
	end

	// done strobes for a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	// a table load never occupies the sequencer
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_LOAD) |=> !busy)
		else $error("table load made the unit busy");

	// a pixel transfer always starts octave work
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_PIXEL) |=> (busy && !done))
		else $error("pixel transfer did not start work");

	// the unit frees up right after a result
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("unit stayed busy after done");

	// the divider only runs with a nonzero weight sum
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> ($past(state_q) == S_M2 && wsum_q != '0))
		else $error("divider started out of sequence");

endmodule

// File: sv/fgn_mul.sv
// shared signed multiplier with registered product
module fgn_mul import fgn_pkg::*; (
	input  logic                     clk,
	input  logic signed [MA_W-1:0]   a,
	input  logic signed [MB_W-1:0]   b,
	output logic signed [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// File: sv/fgn_div.sv
// restoring divider, one quotient bit per cycle, saturated 16-bit quotient
module fgn_div import fgn_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W_DEF,
	parameter int DEN_W = DIV_DEN_W_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_W-1:0]    num,
	input  logic [DEN_W-1:0]    den,
	output logic                done,
	output logic [RESULT_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[NUM_W-1:RESULT_W]) ? {RESULT_W{1'b1}} : quo_q[RESULT_W-1:0];

endmodule
